### rtl/fpbp_pkg.sv
// Shared types and constants for the framed packet byte parser.
package fpbp_pkg;

    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 16;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] CFG_START_BYTE  = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_END_BYTE    = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_ID_LOW      = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_ID_HIGH     = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_MAX_PAYLOAD = 3'd4;

    typedef logic [3:0] t_phase;
    typedef logic [3:0] t_role;

    // Parse phases, which double as the reported parse status.
    localparam t_phase PH_ERROR  = 4'd0;
    localparam t_phase PH_DONE   = 4'd1;
    localparam t_phase PH_START  = 4'd2;
    localparam t_phase PH_ID     = 4'd3;
    localparam t_phase PH_LEN_LO = 4'd4;
    localparam t_phase PH_LEN_HI = 4'd5;
    localparam t_phase PH_DATA   = 4'd6;
    localparam t_phase PH_CHECK  = 4'd7;
    localparam t_phase PH_COMPL  = 4'd8;
    localparam t_phase PH_END    = 4'd9;

    // Byte roles.
    localparam t_role ROLE_REJECT  = 4'd0;
    localparam t_role ROLE_START   = 4'd1;
    localparam t_role ROLE_ID      = 4'd2;
    localparam t_role ROLE_LEN_LO  = 4'd3;
    localparam t_role ROLE_LEN_HI  = 4'd4;
    localparam t_role ROLE_PAYLOAD = 4'd5;
    localparam t_role ROLE_CHECK   = 4'd6;
    localparam t_role ROLE_COMPL   = 4'd7;
    localparam t_role ROLE_END     = 4'd8;

    typedef struct packed {
        logic [7:0]  start_byte;
        logic [7:0]  end_byte;
        logic [7:0]  id_low;
        logic [8:0]  id_high;
        logic [15:0] max_payload;
    } t_cfg;

    typedef struct packed {
        t_phase      parse_status;
        t_role       byte_role;
        logic [7:0]  data_byte;
        logic [7:0]  packet_id;
        logic [15:0] payload_length;
        logic        packet_done;
    } t_result;

endpackage

### rtl/fpbp_cfg_regs.sv
// Configuration register file of the framed packet byte parser.
module fpbp_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [fpbp_pkg::CfgIdxW-1:0]     i_cfg_index,
    input  logic [fpbp_pkg::CfgDataW-1:0]    i_cfg_data,
    output fpbp_pkg::t_cfg                   o_cfg
);
    import fpbp_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_byte  <= 8'd0;
            r_cfg.end_byte    <= 8'd0;
            r_cfg.id_low      <= 8'd0;
            r_cfg.id_high     <= 9'd256;
            r_cfg.max_payload <= 16'd1024;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_START_BYTE:  r_cfg.start_byte  <= i_cfg_data[7:0];
                CFG_END_BYTE:    r_cfg.end_byte    <= i_cfg_data[7:0];
                CFG_ID_LOW:      r_cfg.id_low      <= i_cfg_data[7:0];
                CFG_ID_HIGH:     r_cfg.id_high     <= i_cfg_data[8:0];
                CFG_MAX_PAYLOAD: r_cfg.max_payload <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/fpbp_parser.sv
// Parse state machine: frame state registers and the per-byte next-state logic.
module fpbp_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_rx_byte,
    input  fpbp_pkg::t_cfg    i_cfg,
    output fpbp_pkg::t_result o_result
);
    import fpbp_pkg::*;

    t_phase      r_phase,     n_phase;
    logic [15:0] r_remaining, n_remaining;
    logic [7:0]  r_xor,       n_xor;
    logic [7:0]  r_id,        n_id;
    logic [7:0]  r_len_low,   n_len_low;
    logic [15:0] r_length,    n_length;
    t_role       role;
    logic        done;
    logic [15:0] len_word;

    always_comb begin
        n_phase     = PH_ERROR;
        n_remaining = r_remaining;
        n_xor       = r_xor;
        n_id        = r_id;
        n_len_low   = r_len_low;
        n_length    = r_length;
        role        = ROLE_REJECT;
        done        = 1'b0;
        len_word    = {i_rx_byte, r_len_low};

        unique case (r_phase)
            PH_ERROR, PH_DONE, PH_START: begin
                // Any idle phase clears the frame context before trying a start byte.
                n_id        = 8'd0;
                n_length    = 16'd0;
                n_len_low   = 8'd0;
                n_xor       = 8'd0;
                n_remaining = 16'd0;
                if (i_rx_byte == i_cfg.start_byte) begin
                    role    = ROLE_START;
                    n_phase = PH_ID;
                end
            end
            PH_ID: begin
                if (i_rx_byte >= i_cfg.id_low && {1'b0, i_rx_byte} < i_cfg.id_high) begin
                    n_id    = i_rx_byte;
                    n_xor   = i_rx_byte;
                    role    = ROLE_ID;
                    n_phase = PH_LEN_LO;
                end
            end
            PH_LEN_LO: begin
                n_len_low = i_rx_byte;
                n_xor     = r_xor ^ i_rx_byte;
                role      = ROLE_LEN_LO;
                n_phase   = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                // The announced length is kept even when it is rejected.
                n_length = len_word;
                n_xor    = r_xor ^ i_rx_byte;
                if (len_word <= i_cfg.max_payload) begin
                    role        = ROLE_LEN_HI;
                    n_remaining = len_word;
                    n_phase     = (len_word == 16'd0) ? PH_CHECK : PH_DATA;
                end
            end
            PH_DATA: begin
                n_xor       = r_xor ^ i_rx_byte;
                role        = ROLE_PAYLOAD;
                n_remaining = r_remaining - 16'd1;
                n_phase     = (n_remaining == 16'd0) ? PH_CHECK : PH_DATA;
            end
            PH_CHECK: begin
                if (i_rx_byte == r_xor) begin
                    role    = ROLE_CHECK;
                    n_phase = PH_COMPL;
                end
            end
            PH_COMPL: begin
                if (i_rx_byte == (8'd0 - r_id)) begin
                    role    = ROLE_COMPL;
                    n_phase = PH_END;
                end
            end
            PH_END: begin
                if (i_rx_byte == i_cfg.end_byte) begin
                    role    = ROLE_END;
                    done    = 1'b1;
                    n_phase = PH_DONE;
                end
            end
            default: begin
                n_phase = PH_ERROR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_START;
            r_remaining <= 16'd0;
            r_xor       <= 8'd0;
            r_id        <= 8'd0;
            r_len_low   <= 8'd0;
            r_length    <= 16'd0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_remaining <= n_remaining;
            r_xor       <= n_xor;
            r_id        <= n_id;
            r_len_low   <= n_len_low;
            r_length    <= n_length;
        end
    end

    always_comb begin
        o_result.parse_status   = n_phase;
        o_result.byte_role      = role;
        o_result.data_byte      = (role != ROLE_REJECT) ? i_rx_byte : 8'd0;
        o_result.packet_id      = n_id;
        o_result.payload_length = n_length;
        o_result.packet_done    = done;
    end

endmodule

### rtl/framed_packet_byte_parser_core.sv
// Framed packet byte parser: reports one parse result per received byte. A request is
// accepted whenever the result register is empty or its result is being taken in the
// same cycle, so the block sustains one byte every clock while results drain; each
// result appears in the output register the cycle after its byte is accepted. The
// rate is set by the single parse state register, which updates once per byte, with the
// running XOR and length counter next to it. Configuration must be written while idle.
module framed_packet_byte_parser_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [fpbp_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [fpbp_pkg::CfgDataW-1:0] i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [7:0]                    i_rx_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [3:0]                    o_parse_status,
    output logic [3:0]                    o_byte_role,
    output logic [7:0]                    o_data_byte,
    output logic [7:0]                    o_packet_id,
    output logic [15:0]                   o_payload_length,
    output logic                          o_packet_done
);
    import fpbp_pkg::*;

    t_cfg    cfg;
    t_result n_result;
    t_result r_result;
    logic    r_out_valid;
    logic    in_accept;

    fpbp_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    fpbp_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (in_accept),
        .i_rx_byte (i_rx_byte),
        .i_cfg     (cfg),
        .o_result  (n_result)
    );

    assign o_in_stall = r_out_valid & i_out_stall;
    assign in_accept  = i_in_valid & ~o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_parse_status   = r_result.parse_status;
    assign o_byte_role      = r_result.byte_role;
    assign o_data_byte      = r_result.data_byte;
    assign o_packet_id      = r_result.packet_id;
    assign o_payload_length = r_result.payload_length;
    assign o_packet_done    = r_result.packet_done;

endmodule
